// ===== rtl/assert_macros.svh =====
// assertion helper macros for the line rasterizer rtl
// clocked on clk; ASSERT_CLK is disabled while arst_n is low, ASSERT_ALWAYS is not
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, sampled on the rising clock edge, off during reset
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lr_pkg.sv =====
// shared types and constants for the line rasterizer
// no dependencies
package lr_pkg;

	localparam int COLOR_W = 32;
	localparam int DIM_W   = 15;

	// item operation codes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_idx_t;

	// control from the handshake logic to the line walker
	typedef struct packed {
		logic load;
		logic tick;
	} walk_ctl_t;

endpackage

// ===== rtl/lr_if.sv =====
// valid/ready channel interfaces of the line rasterizer
// depends on lr_pkg
interface lr_cmd_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [lr_pkg::COLOR_W-1:0]   pen_color;

	modport source (output valid, operation, start_x, start_y, end_x, end_y, pen_color,
		input ready);
	modport sink (input valid, operation, start_x, start_y, end_x, end_y, pen_color,
		output ready);
endinterface

interface lr_pix_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [lr_pkg::COLOR_W-1:0]   pixel_color;
	logic                         visible;
	logic                         last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, visible, last, output ready);
endinterface

interface lr_cfg_if;
	logic                     valid;
	logic                     ready;
	lr_pkg::cfg_idx_t         index;
	logic [lr_pkg::DIM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/line_rasterizer_core.sv =====
// A tick on an active line shows its pixel on pix in the next cycle; a load, nothing.
// Throughput: one item per cycle unless pix stalls, set by the single cross product add.
// The output register lets the next item in while a pixel waits, as long as pix.ready
// is high in that cycle. Reset clears the line (no line active), the output valid
// and sets the screen to 640 by 480.
// depends on lr_pkg, lr_if.sv, lr_walker, assert_macros.svh
`include "assert_macros.svh"

module line_rasterizer_core #(
	parameter int COORD_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix,
	lr_cfg_if.sink   cfg
);

	localparam int CMP_W = (COORD_BITS > lr_pkg::DIM_W) ? COORD_BITS : lr_pkg::DIM_W;

	logic [lr_pkg::DIM_W-1:0]     width_q, height_q;
	logic                         out_vld_s1;
	logic signed [COORD_BITS-1:0] pix_x_s1, pix_y_s1;
	logic [lr_pkg::COLOR_W-1:0]   pix_color_s1;
	logic                         pix_vis_s1, pix_last_s1;

	lr_pkg::walk_ctl_t            ctl;
	logic                         cmd_xfer, emit;
	logic                         active, last;
	logic signed [COORD_BITS-1:0] walk_x, walk_y;
	logic [lr_pkg::COLOR_W-1:0]   color;
	logic                         vis;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lr_pkg::DIM_W'(640);
			height_q <= lr_pkg::DIM_W'(480);
		end else if (cfg.valid) begin
			case (cfg.index)
				lr_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg.data;
				lr_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input handshake
	assign cmd.ready = !out_vld_s1 || pix.ready;
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign ctl.load  = cmd_xfer && (cmd.operation == lr_pkg::OP_LOAD);
	assign ctl.tick  = cmd_xfer && (cmd.operation == lr_pkg::OP_TICK);
	assign emit      = ctl.tick && active;

	lr_walker #(
		.COORD_BITS(COORD_BITS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start_x   (cmd.start_x),
		.start_y   (cmd.start_y),
		.end_x     (cmd.end_x),
		.end_y     (cmd.end_y),
		.pen_color (cmd.pen_color),
		.active    (active),
		.last      (last),
		.walk_x    (walk_x),
		.walk_y    (walk_y),
		.color     (color)
	);

	// on-screen test of the current point
	always_comb begin
		vis = !walk_x[COORD_BITS-1] && !walk_y[COORD_BITS-1]
			&& (CMP_W'(unsigned'(walk_x)) < CMP_W'(width_q))
			&& (CMP_W'(unsigned'(walk_y)) < CMP_W'(height_q));
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s1 <= 1'b0;
		end else if (emit) begin
			out_vld_s1 <= 1'b1;
		end else if (pix.ready) begin
			out_vld_s1 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_s1     <= walk_x;
			pix_y_s1     <= walk_y;
			pix_color_s1 <= color;
			pix_vis_s1   <= vis;
			pix_last_s1  <= last;
		end
	end

	assign pix.valid       = out_vld_s1;
	assign pix.pixel_x     = pix_x_s1;
	assign pix.pixel_y     = pix_y_s1;
	assign pix.pixel_color = pix_color_s1;
	assign pix.visible     = pix_vis_s1;
	assign pix.last        = pix_last_s1;

	// checks
	`ASSERT_CLK(a_tick_gives_pixel, emit |=> pix.valid, "tick on active line gave no pixel")
	`ASSERT_CLK(a_last_ends_line, (emit && last) |=> !active, "line still active after last pixel")
	`ASSERT_ALWAYS(a_no_accept_on_stall, (pix.valid && !pix.ready) |-> !cmd.ready,
		"input taken while output stalled")

endmodule

// ===== rtl/lr_walker.sv =====
// line state and 4-connected step decision, one step per tick
// depends on lr_pkg
module lr_walker #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lr_pkg::walk_ctl_t            ctl,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [lr_pkg::COLOR_W-1:0]   pen_color,
	output logic                         active,
	output logic                         last,
	output logic signed [COORD_BITS-1:0] walk_x,
	output logic signed [COORD_BITS-1:0] walk_y,
	output logic [lr_pkg::COLOR_W-1:0]   color
);

	localparam int SPAN_W  = COORD_BITS + 1;
	localparam int STEPS_W = COORD_BITS + 2;
	localparam int STEER_W = 2 * COORD_BITS + 4;

	logic signed [SPAN_W-1:0]     span_x, span_y;
	logic [SPAN_W-1:0]            mag_x, mag_y;
	logic signed [STEER_W-1:0]    span_x_w, span_y_w;
	logic signed [STEER_W-1:0]    xinc_ld, yinc_ld;
	logic signed [COORD_BITS-1:0] dir_x_ld, dir_y_ld;

	logic signed [COORD_BITS-1:0] walk_x_q, walk_y_q;
	logic signed [COORD_BITS-1:0] dir_x_q, dir_y_q;
	logic signed [STEER_W-1:0]    steer_q, xinc_q, yinc_q;
	logic [STEPS_W-1:0]           steps_q;
	logic [lr_pkg::COLOR_W-1:0]   color_q;
	logic                         flip_q, xmajor_q;

	logic steer_zero, steer_pos, step_y;

	// deltas and per-line constants, taken at load
	always_comb begin
		span_x   = SPAN_W'(end_x) - SPAN_W'(start_x);
		span_y   = SPAN_W'(end_y) - SPAN_W'(start_y);
		mag_x    = span_x[SPAN_W-1] ? SPAN_W'(-span_x) : SPAN_W'(span_x);
		mag_y    = span_y[SPAN_W-1] ? SPAN_W'(-span_y) : SPAN_W'(span_y);
		span_x_w = STEER_W'(span_x);
		span_y_w = STEER_W'(span_y);
		// steer change for one x step: sign(dx) * dy
		if (span_x == '0) begin
			xinc_ld = '0;
		end else if (span_x[SPAN_W-1]) begin
			xinc_ld = -span_y_w;
		end else begin
			xinc_ld = span_y_w;
		end
		// steer change for one y step: -sign(dy) * dx
		if (span_y == '0) begin
			yinc_ld = '0;
		end else if (span_y[SPAN_W-1]) begin
			yinc_ld = span_x_w;
		end else begin
			yinc_ld = -span_x_w;
		end
		dir_x_ld = (span_x == '0) ? '0 : (span_x[SPAN_W-1] ? '1 : COORD_BITS'(1));
		dir_y_ld = (span_y == '0) ? '0 : (span_y[SPAN_W-1] ? '1 : COORD_BITS'(1));
	end

	// step decision from the running cross product
	always_comb begin
		steer_zero = (steer_q == '0);
		steer_pos  = !steer_q[STEER_W-1] && !steer_zero;
		step_y     = steer_zero ? !xmajor_q : (steer_pos != flip_q);
	end

	// active-line control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (ctl.load) begin
			steps_q <= STEPS_W'(mag_x) + STEPS_W'(mag_y);
		end else if (ctl.tick && active) begin
			steps_q <= steps_q - STEPS_W'(1);
		end
	end

	// line payload state
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			walk_x_q <= start_x;
			walk_y_q <= start_y;
			dir_x_q  <= dir_x_ld;
			dir_y_q  <= dir_y_ld;
			xinc_q   <= xinc_ld;
			yinc_q   <= yinc_ld;
			steer_q  <= '0;
			color_q  <= pen_color;
			flip_q   <= (span_x[SPAN_W-1] && span_y > 0) || (span_x > 0 && span_y[SPAN_W-1]);
			xmajor_q <= (mag_x >= mag_y);
		end else if (ctl.tick && active) begin
			if (step_y) begin
				walk_y_q <= walk_y_q + dir_y_q;
				steer_q  <= steer_q + yinc_q;
			end else begin
				walk_x_q <= walk_x_q + dir_x_q;
				steer_q  <= steer_q + xinc_q;
			end
		end
	end

	assign active = (steps_q != '0);
	assign last   = (steps_q == STEPS_W'(1));
	assign walk_x = walk_x_q;
	assign walk_y = walk_y_q;
	assign color  = color_q;

endmodule

// ===== test/tb.sv =====
// self-checking bench for line_rasterizer_core: random loads and ticks against a pixel predictor
// depends on lr_pkg, lr_if.sv and the rtl of line_rasterizer_core
module tb;

	localparam int CW         = 16;
	localparam int MAX_CYCLES = 400000;
	localparam int SETTLE     = 4;

	typedef struct {
		lr_pkg::op_t                op;
		logic signed [CW-1:0]       sx;
		logic signed [CW-1:0]       sy;
		logic signed [CW-1:0]       ex;
		logic signed [CW-1:0]       ey;
		logic [lr_pkg::COLOR_W-1:0] color;
	} line_cmd_t;

	typedef struct {
		logic signed [CW-1:0]       x;
		logic signed [CW-1:0]       y;
		logic [lr_pkg::COLOR_W-1:0] color;
		logic                       vis;
		logic                       last;
	} pixel_t;

	logic clk;
	logic arst_n;

	lr_cmd_if #(.COORD_BITS(CW)) cmd ();
	lr_pix_if #(.COORD_BITS(CW)) pix ();
	lr_cfg_if cfg ();

	line_rasterizer_core #(.COORD_BITS(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix),
		.cfg    (cfg)
	);

	// walker state mirrored by the predictor
	logic signed [CW-1:0]       org_x, org_y, cur_x, cur_y;
	logic signed [CW:0]         dx, dy;
	logic [CW+1:0]              remaining;
	logic [lr_pkg::COLOR_W-1:0] line_color;
	logic [lr_pkg::DIM_W-1:0]   scr_w, scr_h;

	line_cmd_t pending[$];
	pixel_t    pixel_exp[$];

	int cycles, queued, accepted, errors;
	int lines_loaded, pixels_checked, offscreen_seen, ends_seen, reg_writes;
	int send_gap, send_calm, recv_stall, recv_calm;
	logic cmd_fire, pix_fire, cfg_fire;

	// per-item wait, with occasional stretches of no waiting at all
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 40) == 0)
			calm_left = $urandom_range(10, 40);
		return $urandom_range(0, 10);
	endfunction

	// advance the mirrored walker by one item; returns 1 when a pixel is due
	function automatic bit trace_step(input line_cmd_t c, output pixel_t px);
		int     ax, ay, sgx, sgy, wx, wy;
		longint steer;
		bit     flip, go_y;
		if (c.op == lr_pkg::OP_LOAD) begin
			org_x      = c.sx;
			org_y      = c.sy;
			cur_x      = c.sx;
			cur_y      = c.sy;
			dx         = {c.ex[CW-1], c.ex} - {c.sx[CW-1], c.sx};
			dy         = {c.ey[CW-1], c.ey} - {c.sy[CW-1], c.sy};
			ax         = (dx < 0) ? -int'(dx) : int'(dx);
			ay         = (dy < 0) ? -int'(dy) : int'(dy);
			remaining  = (CW+2)'(ax + ay);
			line_color = c.color;
			return 0;
		end
		if (remaining == 0)
			return 0;
		wx       = cur_x;
		wy       = cur_y;
		px.x     = cur_x;
		px.y     = cur_y;
		px.color = line_color;
		px.vis   = wx >= 0 && wy >= 0 && wx < int'(scr_w) && wy < int'(scr_h);
		px.last  = remaining == 1;

		// cross product of the walked offset against the line direction
		ax    = (dx < 0) ? -int'(dx) : int'(dx);
		ay    = (dy < 0) ? -int'(dy) : int'(dy);
		sgx   = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
		sgy   = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
		steer = (longint'(cur_x) - longint'(org_x)) * longint'(dy)
			- (longint'(cur_y) - longint'(org_y)) * longint'(dx);
		flip  = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
		if (steer == 0)
			go_y = ax < ay;
		else
			go_y = (steer > 0) != flip;
		if (go_y)
			cur_y = CW'(wy + sgy);
		else
			cur_x = CW'(wx + sgx);
		remaining = remaining - 1'b1;
		return 1;
	endfunction

	function automatic line_cmd_t mk_load(int sx, int sy, int ex, int ey, logic [31:0] color);
		line_cmd_t c;
		c.op    = lr_pkg::OP_LOAD;
		c.sx    = CW'(sx);
		c.sy    = CW'(sy);
		c.ex    = CW'(ex);
		c.ey    = CW'(ey);
		c.color = color;
		return c;
	endfunction

	// a tick carries junk in the unused fields
	function automatic line_cmd_t mk_tick();
		line_cmd_t c;
		c    = mk_load($urandom, $urandom, $urandom, $urandom, $urandom);
		c.op = lr_pkg::OP_TICK;
		return c;
	endfunction

	task automatic push_item(input line_cmd_t c);
		pending.push_back(c);
		queued++;
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(mk_tick());
	endtask

	// coordinate around an edge of the screen or somewhere on it
	function automatic int near_edge(int lim);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, 16)) - 8;
			1: return lim + int'($urandom_range(0, 16)) - 8;
			default: return $urandom_range(0, lim);
		endcase
	endfunction

	// mostly short lines walked to the end, plus wild loads and noise
	task automatic gen_lines(input int budget, input int w, input int h);
		int n, sel, sx, sy, lx, ly, steps, ticks;
		n = 0;
		while (n < budget) begin
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				sx = near_edge(w);
				sy = near_edge(h);
				lx = (sel < 8) ? $urandom_range(0, 60) : $urandom_range(0, 12);
				ly = (sel < 8) ? $urandom_range(0, 60) : $urandom_range(0, 12);
				if ($urandom_range(0, 1)) lx = -lx;
				if ($urandom_range(0, 1)) ly = -ly;
				steps = (lx < 0 ? -lx : lx) + (ly < 0 ? -ly : ly);
				ticks = steps + $urandom_range(0, 2);
				if ($urandom_range(0, 5) == 0)
					ticks = $urandom_range(0, steps);
				push_item(mk_load(sx, sy, sx + lx, sy + ly, $urandom));
				push_ticks(ticks);
				n += 1 + ((ticks < steps) ? ticks : steps);
			end else if (sel < 88) begin
				ticks = $urandom_range(0, 4);
				push_item(mk_load($urandom, $urandom, $urandom, $urandom, $urandom));
				push_ticks(ticks);
				n += 1 + ticks;
			end else begin
				if ($urandom_range(0, 1))
					push_item(mk_tick());
				else
					push_item(mk_load($urandom, $urandom, $urandom, $urandom, $urandom));
				n++;
			end
		end
	endtask

	task automatic write_reg(input lr_pkg::cfg_idx_t idx, input logic [lr_pkg::DIM_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg.valid <= 1'b0;
	endtask

	// every item taken and every pixel seen (or the wait limit hit), then a settle wait
	task automatic wait_idle();
		int n;
		n = 0;
		while ((accepted != queued || pixel_exp.size() != 0) && n < 20000) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want)
			note_error($sformatf("%s expected %0h got %0h", name, want, got));
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command driver
	always @(negedge clk) begin : cmd_driver
		line_cmd_t nxt;
		if (arst_n && (!cmd.valid || cmd_fire)) begin
			if (send_gap > 0) begin
				cmd.valid <= 1'b0;
				send_gap  <= send_gap - 1;
			end else if (pending.size() > 0) begin
				nxt = pending.pop_front();
				cmd.operation <= nxt.op;
				cmd.start_x   <= nxt.sx;
				cmd.start_y   <= nxt.sy;
				cmd.end_x     <= nxt.ex;
				cmd.end_y     <= nxt.ey;
				cmd.pen_color <= nxt.color;
				cmd.valid     <= 1'b1;
				send_gap      <= draw_wait(send_calm);
			end else begin
				cmd.valid <= 1'b0;
			end
		end
	end

	// pixel sink with random back-pressure
	always @(negedge clk) begin : pix_sink
		int stall;
		if (arst_n) begin
			stall = pix_fire ? draw_wait(recv_calm) : recv_stall;
			if (stall > 0) begin
				pix.ready  <= 1'b0;
				recv_stall <= stall - 1;
			end else begin
				pix.ready  <= 1'b1;
				recv_stall <= 0;
			end
		end
	end

	// monitor: check each pixel transfer, then predict from each command transfer
	always @(posedge clk) begin : monitor
		line_cmd_t c;
		pixel_t    want;
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("tb failed");
			$finish;
		end else if (arst_n) begin
			cmd_fire <= cmd.valid && cmd.ready;
			pix_fire <= pix.valid && pix.ready;
			cfg_fire <= cfg.valid && cfg.ready;

			if (cfg.valid && cfg.ready) begin
				reg_writes++;
				case (cfg.index)
					lr_pkg::CFG_SCREEN_WIDTH:  scr_w = cfg.data;
					lr_pkg::CFG_SCREEN_HEIGHT: scr_h = cfg.data;
					default: ;
				endcase
			end

			if (pix.valid && pix.ready) begin
				if (pixel_exp.size() == 0) begin
					note_error($sformatf("unexpected pixel at %0d,%0d",
						pix.pixel_x, pix.pixel_y));
				end else begin
					want = pixel_exp.pop_front();
					pixels_checked++;
					if (!want.vis) offscreen_seen++;
					if (want.last) ends_seen++;
					check_field("pixel_x", 32'(want.x), 32'(pix.pixel_x));
					check_field("pixel_y", 32'(want.y), 32'(pix.pixel_y));
					check_field("pixel_color", want.color, pix.pixel_color);
					check_field("visible", 32'(want.vis), 32'(pix.visible));
					check_field("last", 32'(want.last), 32'(pix.last));
				end
			end

			if (cmd.valid && cmd.ready) begin
				c.op    = lr_pkg::op_t'(cmd.operation);
				c.sx    = cmd.start_x;
				c.sy    = cmd.start_y;
				c.ex    = cmd.end_x;
				c.ey    = cmd.end_y;
				c.color = cmd.pen_color;
				accepted++;
				if (c.op == lr_pkg::OP_LOAD) lines_loaded++;
				if (trace_step(c, want))
					pixel_exp.push_back(want);
			end
		end
	end

	// stimulus
	initial begin
		cycles = 0; queued = 0; accepted = 0; errors = 0;
		lines_loaded = 0; pixels_checked = 0; offscreen_seen = 0; ends_seen = 0;
		reg_writes = 0;
		send_gap = 0; send_calm = 0; recv_stall = 0; recv_calm = 0;
		cmd_fire = 1'b0; pix_fire = 1'b0; cfg_fire = 1'b0;
		org_x = '0; org_y = '0; cur_x = '0; cur_y = '0;
		dx = '0; dy = '0; remaining = '0; line_color = '0;
		scr_w = 15'd640; scr_h = 15'd480;
		cmd.valid = 1'b0; cmd.operation = lr_pkg::OP_LOAD;
		cmd.start_x = '0; cmd.start_y = '0; cmd.end_x = '0; cmd.end_y = '0;
		cmd.pen_color = '0;
		pix.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = lr_pkg::CFG_SCREEN_WIDTH; cfg.data = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: idle tick, zero-length line, full short line with a tick past its end
		push_ticks(1);
		push_item(mk_load(5, 5, 5, 5, 32'h0000_0000));
		push_ticks(1);
		push_item(mk_load(0, 0, 3, 2, 32'hFFFF_FFFF));
		push_ticks(6);
		// flipped rule, near the bottom-left and top-right corners, replaced mid-line
		push_item(mk_load(-2, 478, -5, 482, 32'h1234_5678));
		push_ticks(3);
		push_item(mk_load(639, 0, 641, -2, 32'hA5A5_5A5A));
		push_ticks(2);
		// extreme corners in both directions
		push_item(mk_load(-32768, -32768, 32767, 32767, 32'h8000_0001));
		push_ticks(2);
		push_item(mk_load(32767, 32767, -32768, -32768, 32'h7FFF_FFFE));
		push_ticks(1);
		// vertical line walked to its end
		push_item(mk_load(10, 10, 10, 7, 32'h00FF_00FF));
		push_ticks(3);
		gen_lines(145, 640, 480);
		wait_idle();

		// screen settings: tiny, nominal max, zero-sized, all bits set
		write_reg(lr_pkg::CFG_SCREEN_WIDTH, 15'd1);
		write_reg(lr_pkg::CFG_SCREEN_HEIGHT, 15'd1);
		gen_lines(145, 1, 1);
		wait_idle();
		write_reg(lr_pkg::CFG_SCREEN_WIDTH, 15'd16384);
		write_reg(lr_pkg::CFG_SCREEN_HEIGHT, 15'd16384);
		gen_lines(145, 16384, 16384);
		wait_idle();
		write_reg(lr_pkg::CFG_SCREEN_WIDTH, 15'd0);
		write_reg(lr_pkg::CFG_SCREEN_HEIGHT, 15'd9);
		gen_lines(140, 0, 9);
		wait_idle();
		write_reg(lr_pkg::CFG_SCREEN_WIDTH, 15'd23);
		write_reg(lr_pkg::CFG_SCREEN_HEIGHT, 15'd0);
		gen_lines(140, 23, 0);
		wait_idle();
		write_reg(lr_pkg::CFG_SCREEN_WIDTH, 15'd32767);
		write_reg(lr_pkg::CFG_SCREEN_HEIGHT, 15'd200);
		gen_lines(140, 32767, 200);
		wait_idle();

		if (pixel_exp.size() != 0)
			note_error($sformatf("%0d pixels never arrived", pixel_exp.size()));
		$display("covered %0d commands, %0d line loads, %0d register writes",
			accepted, lines_loaded, reg_writes);
		$display("checked %0d pixels (%0d off screen, %0d line ends), %0d mismatches",
			pixels_checked, offscreen_seen, ends_seen, errors);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lr_pkg.sv
rtl/lr_if.sv
rtl/lr_walker.sv
rtl/line_rasterizer_core.sv
test/tb.sv
